### rtl/core/mbt_pkg.sv
`timescale 1ns / 1ps

package mbt_pkg;

  // point and iterate formats
  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 28;
  localparam int Z_WIDTH     = COORD_WIDTH + 4;
  localparam int HALF_WIDTH  = Z_WIDTH / 2;
  localparam int PROD_WIDTH  = 2 * Z_WIDTH;
  localparam int SUM_WIDTH   = Z_WIDTH + 2;

  // configuration register
  localparam int                    ITER_WIDTH      = 16;
  localparam logic [ITER_WIDTH-1:0] MAX_ITER_RESET  = ITER_WIDTH'(1000);
  localparam int                    ADDR_WIDTH      = 3;
  localparam int                    DATA_WIDTH      = 32;
  localparam logic [ADDR_WIDTH-1:0] ADDR_MAX_ITER   = ADDR_WIDTH'(0);

  // escape when |z|^2 is strictly above 4.0
  localparam logic [Z_WIDTH:0] ESCAPE_LIMIT = (Z_WIDTH + 1)'(4) << FRAC_BITS;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_ACC,
    ST_SCALE,
    ST_CHECK
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic mul_lo;
    logic mul_hi;
    logic acc;
    logic scale;
    logic step;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic escaped;
    logic last;
  } stat_t;

  // saturate a wide signed sum to the iterate range
  function automatic logic signed [Z_WIDTH-1:0] sat_z(input logic signed [SUM_WIDTH-1:0] v);
    logic signed [SUM_WIDTH-1:0] zmax;
    logic signed [SUM_WIDTH-1:0] zmin;
    zmax = SUM_WIDTH'({1'b0, {(Z_WIDTH-1){1'b1}}});
    zmin = -zmax - SUM_WIDTH'(1);
    if (v > zmax) begin
      sat_z = {1'b0, {(Z_WIDTH-1){1'b1}}};
    end else if (v < zmin) begin
      sat_z = {1'b1, {(Z_WIDTH-1){1'b0}}};
    end else begin
      sat_z = v[Z_WIDTH-1:0];
    end
  endfunction

  // floor of a signed product given as magnitude and sign, shifted right, saturated
  function automatic logic signed [Z_WIDTH-1:0] scale_sat(input logic [PROD_WIDTH-1:0] m,
                                                          input logic neg,
                                                          input int sh);
    logic [PROD_WIDTH:0] t;
    logic [PROD_WIDTH:0] r;
    logic [PROD_WIDTH:0] mask;
    mask = ((PROD_WIDTH + 1)'(1) << sh) - (PROD_WIDTH + 1)'(1);
    t = neg ? ({1'b0, m} + mask) : {1'b0, m};
    r = t >> sh;
    if (|r[PROD_WIDTH:Z_WIDTH-1]) begin
      scale_sat = neg ? {1'b1, {(Z_WIDTH-1){1'b0}}} : {1'b0, {(Z_WIDTH-1){1'b1}}};
    end else begin
      scale_sat = neg ? -$signed(r[Z_WIDTH-1:0]) : $signed(r[Z_WIDTH-1:0]);
    end
  endfunction

endpackage

### rtl/core/mbt_ctrl.sv
`timescale 1ns / 1ps

module mbt_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           out_free,
  input  mbt_pkg::stat_t stat,
  output mbt_pkg::cmd_t  cmd,
  output logic           idle,
  output logic           done,
  output logic           result
);

  mbt_pkg::state_t state;
  mbt_pkg::state_t state_next;
  logic            finish;

  // a point is finished on escape or when the update budget is used up
  assign finish = stat.escaped || stat.last;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mbt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      mbt_pkg::ST_IDLE: begin
        if (start) state_next = mbt_pkg::ST_MUL_LO;
      end
      mbt_pkg::ST_MUL_LO: state_next = mbt_pkg::ST_MUL_HI;
      mbt_pkg::ST_MUL_HI: state_next = mbt_pkg::ST_ACC;
      mbt_pkg::ST_ACC:    state_next = mbt_pkg::ST_SCALE;
      mbt_pkg::ST_SCALE:  state_next = mbt_pkg::ST_CHECK;
      mbt_pkg::ST_CHECK: begin
        if (!finish) begin
          state_next = mbt_pkg::ST_MUL_LO;
        end else if (out_free) begin
          state_next = mbt_pkg::ST_IDLE;
        end
      end
      default: state_next = mbt_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd    = '0;
    idle   = 1'b0;
    done   = 1'b0;
    result = !stat.escaped;
    unique case (state)
      mbt_pkg::ST_IDLE: begin
        idle     = 1'b1;
        cmd.load = start;
      end
      mbt_pkg::ST_MUL_LO: cmd.mul_lo = 1'b1;
      mbt_pkg::ST_MUL_HI: cmd.mul_hi = 1'b1;
      mbt_pkg::ST_ACC:    cmd.acc    = 1'b1;
      mbt_pkg::ST_SCALE:  cmd.scale  = 1'b1;
      mbt_pkg::ST_CHECK: begin
        cmd.step = !finish;
        done     = finish && out_free;
      end
      default: idle = 1'b0;
    endcase
  end

endmodule

### rtl/core/mbt_datapath.sv
`timescale 1ns / 1ps

module mbt_datapath (
  input  logic                                     clk,
  input  mbt_pkg::cmd_t                            cmd,
  input  logic signed [mbt_pkg::COORD_WIDTH-1:0]   cx,
  input  logic signed [mbt_pkg::COORD_WIDTH-1:0]   cy,
  input  logic [mbt_pkg::ITER_WIDTH-1:0]           max_iterations,
  output mbt_pkg::stat_t                           stat
);

  localparam int ZW   = mbt_pkg::Z_WIDTH;
  localparam int HW   = mbt_pkg::HALF_WIDTH;
  localparam int PW   = mbt_pkg::PROD_WIDTH;
  localparam int SW   = mbt_pkg::SUM_WIDTH;
  localparam int MW   = ZW + HW;
  localparam int NPR  = 3;
  localparam int P_AA = 0;
  localparam int P_BB = 1;
  localparam int P_AB = 2;

  logic signed [mbt_pkg::COORD_WIDTH-1:0] cx_q;
  logic signed [mbt_pkg::COORD_WIDTH-1:0] cy_q;
  logic signed [ZW-1:0]                   a;
  logic signed [ZW-1:0]                   b;
  logic [mbt_pkg::ITER_WIDTH-1:0]         count;

  logic [ZW-1:0]        mag_a;
  logic [ZW-1:0]        mag_b;
  logic [ZW-1:0]        mx    [NPR];
  logic [ZW-1:0]        my    [NPR];
  logic                 neg   [NPR];
  logic [HW-1:0]        half  [NPR];
  logic [MW-1:0]        mprod [NPR];
  logic [MW-1:0]        p_lo  [NPR];
  logic [MW-1:0]        p_hi  [NPR];
  logic [PW-1:0]        full  [NPR];
  logic signed [ZW-1:0] q     [NPR];

  logic [ZW:0]          mag_sq;
  logic signed [SW-1:0] re_sum;
  logic signed [SW-1:0] im_sum;

  // operand magnitudes and product signs
  assign mag_a = a[ZW-1] ? ZW'(-a) : ZW'(a);
  assign mag_b = b[ZW-1] ? ZW'(-b) : ZW'(b);

  always_comb begin
    mx[P_AA]  = mag_a;
    my[P_AA]  = mag_a;
    neg[P_AA] = 1'b0;
    mx[P_BB]  = mag_b;
    my[P_BB]  = mag_b;
    neg[P_BB] = 1'b0;
    mx[P_AB]  = mag_a;
    my[P_AB]  = mag_b;
    neg[P_AB] = a[ZW-1] ^ b[ZW-1];
  end

  // one full by half multiplier per product, low half then high half
  always_comb begin
    for (int k = 0; k < NPR; k++) begin
      half[k]  = cmd.mul_hi ? my[k][ZW-1:HW] : my[k][HW-1:0];
      mprod[k] = MW'(mx[k]) * MW'(half[k]);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NPR; k++) begin
      if (cmd.mul_lo) p_lo[k] <= mprod[k];
      if (cmd.mul_hi) p_hi[k] <= mprod[k];
      if (cmd.acc) full[k] <= PW'(p_lo[k]) + (PW'(p_hi[k]) << HW);
    end
  end

  // rescale and saturate the products
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      q[P_AA] <= '0;
      q[P_BB] <= '0;
      q[P_AB] <= '0;
    end else if (cmd.scale) begin
      q[P_AA] <= mbt_pkg::scale_sat(full[P_AA], neg[P_AA], mbt_pkg::FRAC_BITS);
      q[P_BB] <= mbt_pkg::scale_sat(full[P_BB], neg[P_BB], mbt_pkg::FRAC_BITS);
      q[P_AB] <= mbt_pkg::scale_sat(full[P_AB], neg[P_AB], mbt_pkg::FRAC_BITS - 1);
    end
  end

  // escape test on the squares of the current iterate
  assign mag_sq = {1'b0, q[P_AA]} + {1'b0, q[P_BB]};

  assign stat.escaped = (mag_sq > mbt_pkg::ESCAPE_LIMIT);
  assign stat.last    = (count == max_iterations);

  // z update sums
  assign re_sum = SW'(q[P_AA]) - SW'(q[P_BB]) + SW'(cx_q);
  assign im_sum = SW'(q[P_AB]) + SW'(cy_q);

  // iterate, point and update count
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cx_q  <= cx;
      cy_q  <= cy;
      a     <= '0;
      b     <= '0;
      count <= '0;
    end else if (cmd.step) begin
      a     <= mbt_pkg::sat_z(re_sum);
      b     <= mbt_pkg::sat_z(im_sum);
      count <= count + mbt_pkg::ITER_WIDTH'(1);
    end
  end

endmodule

### rtl/core/mandelbrot_membership_test.sv
`timescale 1ns / 1ps

// mandelbrot membership test
// request channel: in_valid/in_ready carries one point (cx, cy), signed
// Q3.28. in_ready is high whenever the block holds no point in progress.
// result channel: out_valid/out_ready carries in_set, 1 when z = z*z + c
// started at zero never left |z|^2 <= 4 within max_iterations updates.
// config: APB register max_iterations at byte address 0 (16 bits, reset
// 1000); write it only while no point is in progress.
// z update: each runs on the three shared 36x18 multipliers through the
// steps low half, high half, accumulate, rescale, check.
// One point at a time.
// a finished result waits in an output register; the next request is
// taken meanwhile, and a second finished result holds in the check step
// until out_ready frees the register.
// reset: synchronous, active high; clears the controller, the output
// valid flag and restores max_iterations to 1000.

module mandelbrot_membership_test (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [mbt_pkg::COORD_WIDTH-1:0] cx,
  input  logic signed [mbt_pkg::COORD_WIDTH-1:0] cy,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic                                   in_set,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [mbt_pkg::ADDR_WIDTH-1:0]         paddr,
  input  logic [mbt_pkg::DATA_WIDTH-1:0]         pwdata,
  output logic [mbt_pkg::DATA_WIDTH-1:0]         prdata,
  output logic                                   pready
);

  logic [mbt_pkg::ITER_WIDTH-1:0] max_iterations;
  mbt_pkg::cmd_t                  cmd;
  mbt_pkg::stat_t                 stat;
  logic                           idle;
  logic                           done;
  logic                           result;
  logic                           out_free;
  logic                           start;

  // config register
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_iterations <= mbt_pkg::MAX_ITER_RESET;
    end else if (psel && penable && pwrite && pready && paddr == mbt_pkg::ADDR_MAX_ITER) begin
      max_iterations <= pwdata[mbt_pkg::ITER_WIDTH-1:0];
    end
  end

  assign prdata = (paddr == mbt_pkg::ADDR_MAX_ITER) ?
                  mbt_pkg::DATA_WIDTH'(max_iterations) : '0;

  // request handshake
  assign in_ready = idle;
  assign start    = in_valid && idle;

  // result register
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) in_set <= result;
  end

  mbt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .out_free (out_free),
    .stat     (stat),
    .cmd      (cmd),
    .idle     (idle),
    .done     (done),
    .result   (result)
  );

  mbt_datapath u_datapath (
    .clk            (clk),
    .cmd            (cmd),
    .cx             (cx),
    .cy             (cy),
    .max_iterations (max_iterations),
    .stat           (stat)
  );

endmodule

### sim/mandelbrot_membership_test_tb.sv
`timescale 1ns / 1ps

module mandelbrot_membership_test_tb;
  import mbt_pkg::*;

  typedef struct packed {
    logic [COORD_WIDTH-1:0] re;
    logic [COORD_WIDTH-1:0] im;
  } point_t;

  localparam int                    ONE_Q       = 1 << FRAC_BITS;
  localparam logic [ADDR_WIDTH-1:0] ADDR_SPARE  = ADDR_WIDTH'(4);
  localparam int                    PRESCREEN   = 601;
  localparam int                    HOLD_CYCLES = 400;
  localparam longint                Z_HI        = (longint'(1) <<< (Z_WIDTH - 1)) - 1;
  localparam longint                Z_LO        = -Z_HI - 1;
  localparam longint                BAILOUT     = longint'(4) <<< FRAC_BITS;

  logic                          clk       = 1'b0;
  logic                          rst       = 1'b1;
  logic                          in_valid  = 1'b0;
  logic                          in_ready;
  logic signed [COORD_WIDTH-1:0] cx        = '0;
  logic signed [COORD_WIDTH-1:0] cy        = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic                          in_set;
  logic                          psel      = 1'b0;
  logic                          penable   = 1'b0;
  logic                          pwrite    = 1'b0;
  logic [ADDR_WIDTH-1:0]         paddr     = '0;
  logic [DATA_WIDTH-1:0]         pwdata    = '0;
  logic [DATA_WIDTH-1:0]         prdata;
  logic                          pready;

  point_t                point_q[$];
  bit                    verdict_q[$];
  logic [ITER_WIDTH-1:0] iter_limit = MAX_ITER_RESET;
  logic                  req_taken  = 1'b0;
  bit                    steady     = 1'b0;
  bit                    held       = 1'b0;
  int                    hold_at    = 0;
  int                    hold_left  = 0;
  int                    n_done     = 0;
  int                    n_inside   = 0;
  int                    n_limits   = 0;
  int                    errors     = 0;
  bit                    want;
  point_t                nxt;

  mandelbrot_membership_test dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .cx(cx), .cy(cy),
    .out_valid(out_valid), .out_ready(out_ready), .in_set(in_set),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // clamp to the iterate range
  function automatic longint clamp_z(input logic signed [2*Z_WIDTH-1:0] v);
    if (v > Z_HI) return Z_HI;
    if (v < Z_LO) return Z_LO;
    return longint'(v);
  endfunction

  // floor(x*y / 2^sh), clamped
  function automatic longint fx_mul(input longint x, input longint y, input int sh);
    logic signed [2*Z_WIDTH-1:0] p;
    p = x * y;
    return clamp_z(p >>> sh);
  endfunction

  // escape-time iteration from z = 0
  function automatic bit point_in_set(input logic signed [COORD_WIDTH-1:0] re,
                                      input logic signed [COORD_WIDTH-1:0] im,
                                      input int lim);
    longint a;
    longint b;
    longint na;
    longint nb;
    a = 0;
    b = 0;
    for (int k = 0; k < lim; k++) begin
      na = clamp_z(fx_mul(a, a, FRAC_BITS) - fx_mul(b, b, FRAC_BITS) + re);
      nb = clamp_z(fx_mul(a, b, FRAC_BITS - 1) + im);
      a = na;
      b = nb;
      if (fx_mul(a, a, FRAC_BITS) + fx_mul(b, b, FRAC_BITS) > BAILOUT) return 1'b0;
    end
    return 1'b1;
  endfunction

  // mostly points near the set, some mid-range, some anywhere
  function automatic point_t random_point();
    point_t p;
    int pick;
    pick = $urandom_range(99);
    if (pick < 65) begin
      p.re = 32'($urandom_range(3 * ONE_Q)) - 32'(ONE_Q / 4 * 9);
      p.im = 32'($urandom_range(3 * ONE_Q)) - 32'(ONE_Q * 3 / 2);
    end else if (pick < 80) begin
      p.re = 32'($urandom_range(8 * ONE_Q - 1)) - 32'(4 * ONE_Q);
      p.im = 32'($urandom_range(8 * ONE_Q - 1)) - 32'(4 * ONE_Q);
    end else begin
      p.re = $urandom();
      p.im = $urandom();
    end
    return p;
  endfunction

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_taken) begin
      if (point_q.size() > 0 && (steady || $urandom_range(99) >= 26)) begin
        nxt = point_q.pop_front();
        in_valid <= 1'b1;
        cx <= nxt.re;
        cy <= nxt.im;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result acceptance, with one long hold-off
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!held && hold_at > 0 && n_done >= hold_at) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      held <= 1'b1;
    end else begin
      out_ready <= steady || ($urandom_range(99) >= 26);
    end
  end

  // predict on request, check on result
  always @(posedge clk) begin
    req_taken <= !rst && in_valid && in_ready;
    if (!rst) begin
      if (in_valid && in_ready) begin
        verdict_q.push_back(point_in_set(cx, cy, int'(iter_limit)));
      end
      if (out_valid && out_ready) begin
        n_done++;
        if (in_set) n_inside++;
        if (verdict_q.size() == 0) begin
          $display("%0t: in_set expected none, got %0b", $time, in_set);
          errors++;
        end else begin
          want = verdict_q.pop_front();
          if (in_set !== want) begin
            $display("%0t: in_set expected %0b, got %0b", $time, want, in_set);
            errors++;
          end
        end
      end
    end
  end

  task automatic apb_write(input logic [ADDR_WIDTH-1:0] addr, input logic [DATA_WIDTH-1:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_MAX_ITER) iter_limit = data[ITER_WIDTH-1:0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // read back max_iterations
  task automatic apb_check();
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_MAX_ITER;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== DATA_WIDTH'(iter_limit)) begin
      $display("%0t: prdata expected %0d, got %0d", $time, iter_limit, prdata);
      errors++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // wait until every request is in and every result is out
  task automatic drain();
    while (point_q.size() != 0 || in_valid || verdict_q.size() != 0) @(negedge clk);
  endtask

  task automatic run_phase(input logic [DATA_WIDTH-1:0] wval, input int count);
    point_t pt;
    apb_write(ADDR_MAX_ITER, wval);
    apb_check();
    n_limits++;
    @(posedge clk);
    for (int i = 0; i < count; i++) begin
      pt = random_point();
      // at large limits keep points that escape early, plus one bounded point
      if (iter_limit > 1000) begin
        if (i == 0) pt = '0;
        else while (point_in_set(pt.re, pt.im, PRESCREEN)) pt = random_point();
      end
      point_q.push_back(pt);
    end
    drain();
  endtask

  // time limit
  initial begin
    #40_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // reset value, then a write to an unmapped register
    apb_check();
    apb_write(ADDR_SPARE, 32'h0000_0005);
    apb_check();
    n_limits++;

    // directed points at the reset limit
    @(posedge clk);
    point_q.push_back('{re: 32'(0),              im: 32'(0)});
    point_q.push_back('{re: 32'(-2 * ONE_Q),     im: 32'(0)});
    point_q.push_back('{re: 32'(ONE_Q / 4),      im: 32'(0)});
    point_q.push_back('{re: 32'(0),              im: 32'(ONE_Q)});
    point_q.push_back('{re: 32'(-ONE_Q),         im: 32'(0)});
    point_q.push_back('{re: 32'(-7 * ONE_Q / 4), im: 32'(0)});
    point_q.push_back('{re: 32'(ONE_Q / 4 + ONE_Q / 64), im: 32'(0)});
    point_q.push_back('{re: 32'(-3 * ONE_Q / 4), im: 32'(ONE_Q / 8)});
    point_q.push_back('{re: 32'(2 * ONE_Q),      im: 32'(0)});
    point_q.push_back('{re: 32'h7FFF_FFFF,       im: 32'(0)});
    point_q.push_back('{re: 32'h8000_0000,       im: 32'h8000_0000});
    point_q.push_back('{re: 32'(0),              im: 32'h7FFF_FFFF});
    point_q.push_back('{re: 32'(0),              im: 32'h8000_0000});
    point_q.push_back('{re: 32'h7FFF_FFFF,       im: 32'h7FFF_FFFF});
    point_q.push_back('{re: 32'h8000_0000,       im: 32'h7FFF_FFFF});
    drain();

    // zero limit, with the result side held off for a while
    hold_at = n_done + 20;
    run_phase(32'd0, 100);
    run_phase(32'd1, 60);
    run_phase(32'd2, 60);
    steady = 1'b1;
    run_phase(32'd12, 100);
    steady = 1'b0;
    run_phase(32'd50, 100);
    // upper bits of the write are dropped, leaving 200
    run_phase(32'hABCD_00C8, 60);
    run_phase(32'h0000_FFFF, 60);
    run_phase(32'd7, 60);

    repeat (60) @(posedge clk);
    $display("checked %0d points under %0d iteration limits, 0 through 65535", n_done, n_limits);
    $display("%0d points stayed bounded, %0d escaped", n_inside, n_done - n_inside);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
